/* rtl/gne_pkg.sv */
// Shared constants, types and the divider step for the grid neighbor enumerator.
package gne_pkg;

    // Grid limits and field widths
    localparam int MAX_GRID_DIM   = 1024;
    localparam int DIM_W          = 11;
    localparam int IDX_W          = 20;
    localparam int DIR_W          = 3;
    localparam int NUM_DIRS       = 8;
    localparam int CFG_ADDR_W     = 1;

    // Divider pipeline shape: quotient bits resolved per stage
    localparam int DIV_STAGES     = 5;
    localparam int BITS_PER_STAGE = IDX_W / DIV_STAGES;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Offset codes for column and row steps
    typedef logic [1:0] t_ofs;
    localparam t_ofs OFS_NEG  = 2'd0;
    localparam t_ofs OFS_ZERO = 2'd1;
    localparam t_ofs OFS_POS  = 2'd2;

    // Fixed visiting order, column offset major, center skipped
    localparam t_ofs DCOL_TAB [NUM_DIRS] = '{OFS_NEG, OFS_NEG, OFS_NEG, OFS_ZERO,
                                             OFS_ZERO, OFS_POS, OFS_POS, OFS_POS};
    localparam t_ofs DROW_TAB [NUM_DIRS] = '{OFS_NEG, OFS_ZERO, OFS_POS, OFS_NEG,
                                             OFS_POS, OFS_NEG, OFS_ZERO, OFS_POS};

    // Partial state of the restoring divider: remainder, and a word whose
    // upper bits are dividend still to consume and lower bits the quotient
    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] sh;
    } t_div_st;

    // Divider result handed to the neighbor prep stage
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [DIM_W-1:0] col;
        logic [IDX_W-1:0] row;
    } t_split;

    // One center cell ready for enumeration
    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [IDX_W-1:0]    up;
        logic [IDX_W-1:0]    dn;
        logic [NUM_DIRS-1:0] mask;
    } t_job;

    // One restoring-division step
    function automatic t_div_st div_step(t_div_st s, logic [DIM_W-1:0] divisor);
        logic [DIM_W:0] trial;
        logic           qbit;
        t_div_st        r;
        trial = {s.rem, s.sh[IDX_W-1]};
        if (trial >= {1'b0, divisor}) begin
            qbit  = 1'b1;
            r.rem = DIM_W'(trial - {1'b0, divisor});
        end else begin
            qbit  = 1'b0;
            r.rem = trial[DIM_W-1:0];
        end
        r.sh = {s.sh[IDX_W-2:0], qbit};
        return r;
    endfunction

endpackage

/* rtl/gne_div_pipe.sv */
// Pipelined restoring divider: splits a cell index into column and row.
module gne_div_pipe
    import gne_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IDX_W-1:0] i_idx,
    input  logic [DIM_W-1:0] i_width,
    output logic             o_valid,
    input  logic             i_ready,
    output t_split           o_split
);

    logic [DIV_STAGES-1:0] r_valid;
    t_div_st               r_st  [DIV_STAGES];
    logic [IDX_W-1:0]      r_idx [DIV_STAGES];
    t_div_st               n_st  [DIV_STAGES];
    logic [DIV_STAGES-1:0] stg_rdy;

    // Stage may load when empty or when its content moves on
    always_comb begin
        stg_rdy[DIV_STAGES-1] = !r_valid[DIV_STAGES-1] || i_ready;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_valid[k] || stg_rdy[k+1];
        end
    end

    // Each stage resolves BITS_PER_STAGE quotient bits
    always_comb begin
        t_div_st cur;
        cur.rem = '0;
        cur.sh  = i_idx;
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
            cur = div_step(cur, i_width);
        end
        n_st[0] = cur;
        for (int k = 1; k < DIV_STAGES; k++) begin
            cur = r_st[k-1];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                cur = div_step(cur, i_width);
            end
            n_st[k] = cur;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < DIV_STAGES; k++) begin
                if (stg_rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_st[0]  <= n_st[0];
            r_idx[0] <= i_idx;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (stg_rdy[k]) begin
                r_st[k]  <= n_st[k];
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    assign o_ready     = stg_rdy[0];
    assign o_valid     = r_valid[DIV_STAGES-1];
    assign o_split.idx = r_idx[DIV_STAGES-1];
    assign o_split.col = r_st[DIV_STAGES-1].rem;
    assign o_split.row = r_st[DIV_STAGES-1].sh;

endmodule

/* rtl/gne_emit.sv */
// Neighbor emitter: walks the in-bounds mask of one cell, one result per cycle unless stalled.
module gne_emit
    import gne_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_job             i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [IDX_W-1:0] o_neighbor_index,
    output logic [DIR_W-1:0] o_neighbor_dir,
    output logic             o_last_neighbor
);

    logic [NUM_DIRS-1:0] r_mask;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_up;
    logic [IDX_W-1:0]    r_dn;
    logic                r_out_valid;
    logic [IDX_W-1:0]    r_out_idx;
    logic [DIR_W-1:0]    r_out_dir;
    logic                r_out_last;

    logic                active;
    logic                out_free;
    logic                emit;
    logic                in_rdy;
    logic [DIR_W-1:0]    sel_dir;
    logic [NUM_DIRS-1:0] rest;
    logic [IDX_W-1:0]    base;
    logic [IDX_W-1:0]    n_idx;

    // Lowest pending direction
    always_comb begin
        logic found;
        found   = 1'b0;
        sel_dir = '0;
        for (int d = 0; d < NUM_DIRS; d++) begin
            if (r_mask[d] && !found) begin
                sel_dir = DIR_W'(d);
                found   = 1'b1;
            end
        end
        rest = r_mask & ~(NUM_DIRS'(1) << sel_dir);
    end

    // Neighbor index: row base, then column step
    always_comb begin
        unique case (DROW_TAB[sel_dir])
            OFS_NEG: base = r_up;
            OFS_POS: base = r_dn;
            default: base = r_idx;
        endcase
        unique case (DCOL_TAB[sel_dir])
            OFS_NEG: n_idx = base - IDX_W'(1);
            OFS_POS: n_idx = base + IDX_W'(1);
            default: n_idx = base;
        endcase
    end

    assign active   = |r_mask;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = active && out_free;
    assign in_rdy   = !active || (emit && rest == '0);

    // Pending mask and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_rdy) begin
                r_mask <= i_valid ? i_job.mask : '0;
            end else if (emit) begin
                r_mask <= rest;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (in_rdy && i_valid) begin
            r_idx <= i_job.idx;
            r_up  <= i_job.up;
            r_dn  <= i_job.dn;
        end
        if (emit) begin
            r_out_idx  <= n_idx;
            r_out_dir  <= sel_dir;
            r_out_last <= (rest == '0);
        end
    end

    assign o_ready          = in_rdy;
    assign o_valid          = r_out_valid;
    assign o_neighbor_index = r_out_idx;
    assign o_neighbor_dir   = r_out_dir;
    assign o_last_neighbor  = r_out_last;

endmodule

/* rtl/grid_neighbor_enumerator.sv */
// Top level of the eight-connected grid neighbor enumerator.
//
// Usage: write grid_width (index 0) and grid_height (index 1) through the
// write port while the block is idle; values above 1024 saturate to 1024.
// Each item on the input channel is a row-major cell index. The block splits
// it into column and row and returns one item per in-bounds neighbor, in
// fixed order (column offset major, center skipped), with the final one
// flagged by o_last_neighbor. A cell with no in-bounds neighbor (1x1 grid,
// zero dimension, index far beyond the grid) produces no output at all.
// The accepting edge loads the first of five divider stages at four quotient
// bits each; four more divider stages, the prep stage, the emitter and the
// output register follow before the first neighbor is valid. The output port
// moves one neighbor per cycle while the receiver does not stall; a cell
// yields one item per in-bounds neighbor (up to 8, possibly none); cells
// enter back to back otherwise.
// Reset (synchronous, active low) empties the pipeline and sets both grid
// dimensions to 1. When the receiver stalls, the output holds and the
// pipeline fills up, then o_ready drops; nothing is lost or repeated.
module grid_neighbor_enumerator
    import gne_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [DIM_W-1:0]      i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [IDX_W-1:0]      i_cell_index,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [IDX_W-1:0]      o_neighbor_index,
    output logic [DIR_W-1:0]      o_neighbor_dir,
    output logic                  o_last_neighbor
);

    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [DIM_W-1:0] cfg_sat;

    logic             div_valid;
    logic             div_ready;
    t_split           div_split;

    logic             r_p_valid;
    t_job             r_job;
    t_job             n_job;
    logic             p_rdy;
    logic             emit_rdy;

    // Configuration registers with saturation
    assign cfg_sat = (i_cfg_wdata > DIM_W'(MAX_GRID_DIM)) ? DIM_W'(MAX_GRID_DIM) : i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_W'(1);
            r_grid_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_GRID_WIDTH:  r_grid_width  <= cfg_sat;
                REG_GRID_HEIGHT: r_grid_height <= cfg_sat;
                default: ;
            endcase
        end
    end

    // Column / row split
    gne_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_idx   (i_cell_index),
        .i_width (r_grid_width),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_split (div_split)
    );

    // Prep: bounds mask and the rows above and below
    always_comb begin
        logic dims_ok, c_m, c_p, r_m, r_0, r_p;
        dims_ok = (r_grid_width != '0) && (r_grid_height != '0);
        c_m     = (div_split.col != '0);
        c_p     = ({1'b0, div_split.col} + (DIM_W+1)'(1)) < {1'b0, r_grid_width};
        r_m     = (div_split.row != '0) && (div_split.row <= IDX_W'(r_grid_height));
        r_0     = div_split.row < IDX_W'(r_grid_height);
        r_p     = ({1'b0, div_split.row} + (IDX_W+1)'(1)) < (IDX_W+1)'(r_grid_height);
        n_job.idx  = div_split.idx;
        n_job.up   = div_split.idx - IDX_W'(r_grid_width);
        n_job.dn   = div_split.idx + IDX_W'(r_grid_width);
        n_job.mask = {c_p & r_p, c_p & r_0, c_p & r_m, r_p, r_m,
                      c_m & r_p, c_m & r_0, c_m & r_m} & {NUM_DIRS{dims_ok}};
    end

    assign p_rdy     = !r_p_valid || emit_rdy;
    assign div_ready = p_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_rdy) begin
            r_p_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_rdy) begin
            r_job <= n_job;
        end
    end

    // Enumeration and output register
    gne_emit u_emit (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_p_valid),
        .o_ready          (emit_rdy),
        .i_job            (r_job),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_neighbor_index (o_neighbor_index),
        .o_neighbor_dir   (o_neighbor_dir),
        .o_last_neighbor  (o_last_neighbor)
    );

endmodule

/* rtl/gne_checker.sv */
// Port-level checks for the grid neighbor enumerator, bound to the top level.
module gne_checker
    import gne_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [IDX_W-1:0]      o_neighbor_index,
    input logic [DIR_W-1:0]      o_neighbor_dir,
    input logic                  o_last_neighbor
);

    // Output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_neighbor_index)
            && $stable(o_neighbor_dir) && $stable(o_last_neighbor))
        else $error("stalled result changed");

    // Within one cell, the next neighbor follows at once with a higher direction
    a_dir_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_neighbor |=>
            o_valid && (o_neighbor_dir > $past(o_neighbor_dir)))
        else $error("neighbor order broken");

    // The last direction always closes its cell
    a_dir7_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_neighbor_dir == DIR_W'(NUM_DIRS - 1)) |-> o_last_neighbor)
        else $error("final direction not flagged last");

endmodule

bind grid_neighbor_enumerator gne_checker u_gne_checker (.*);
